>>> rtl/core/v3alu_pkg.sv
// ----------------------------------------------------------------------------
// Vector ALU package
// Opcodes, widths, the context record that travels down the pipeline and the
// saturation helpers shared by the vector arithmetic unit.
// ----------------------------------------------------------------------------
package v3alu_pkg;

   localparam int DATA_W = 32;
   localparam int FRAC_W = 16;
   localparam int OP_W   = 4;
   localparam int WIDE_W = 50;
   localparam int PROD_W = 2 * DATA_W;
   localparam int SHPR_W = PROD_W - FRAC_W;
   localparam int RAD_W  = 2 * DATA_W;
   localparam int ROOT_W = DATA_W;
   localparam int REM_W  = DATA_W + 2;
   localparam int DIVD_W = DATA_W + FRAC_W;
   localparam int SQ_STAGES = ROOT_W;
   localparam int DV_STAGES = DIVD_W;

   localparam logic [OP_W-1:0] OP_ADD   = 4'd0;
   localparam logic [OP_W-1:0] OP_SUB   = 4'd1;
   localparam logic [OP_W-1:0] OP_NEG   = 4'd2;
   localparam logic [OP_W-1:0] OP_SCALE = 4'd3;
   localparam logic [OP_W-1:0] OP_DIV   = 4'd4;
   localparam logic [OP_W-1:0] OP_DOT   = 4'd5;
   localparam logic [OP_W-1:0] OP_CROSS = 4'd6;
   localparam logic [OP_W-1:0] OP_MAG   = 4'd7;
   localparam logic [OP_W-1:0] OP_DIST  = 4'd8;
   localparam logic [OP_W-1:0] OP_NORM  = 4'd9;
   localparam logic [OP_W-1:0] OP_EQUAL = 4'd10;

   localparam logic signed [WIDE_W-1:0] WIDE_MAX = 50'sd2147483647;
   localparam logic signed [WIDE_W-1:0] WIDE_MIN = -50'sd2147483648;
   localparam logic [DATA_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;

   typedef struct packed {
      logic [OP_W-1:0]              op;
      logic [2:0][DATA_W-1:0]       a;
      logic [DATA_W-1:0]            s;
      logic [2:0][DATA_W-1:0]       r;
      logic [DATA_W-1:0]            sc;
      logic                         eq;
      logic                         dz;
      logic                         st;
   } ctx_type;

   function automatic logic signed [WIDE_W-1:0] wide32(input logic [DATA_W-1:0] v);
      return {{(WIDE_W-DATA_W){v[DATA_W-1]}}, v};
   endfunction

   function automatic logic [DATA_W-1:0] sat_val(input logic signed [WIDE_W-1:0] v);
      if (v > WIDE_MAX) begin
         return VAL_MAX;
      end else if (v < WIDE_MIN) begin
         return VAL_MIN;
      end
      return v[DATA_W-1:0];
   endfunction

   function automatic logic sat_ovf(input logic signed [WIDE_W-1:0] v);
      return (v > WIDE_MAX) || (v < WIDE_MIN);
   endfunction

   function automatic logic [DATA_W-1:0] abs32(input logic [DATA_W-1:0] v);
      return v[DATA_W-1] ? (~v + 32'd1) : v;
   endfunction

endpackage

>>> rtl/core/vector3_arithmetic_unit_top.sv
// ----------------------------------------------------------------------------
// Vector ALU top level
// Pipelined three-dimensional vector unit in signed Q16.16 fixed point.
//
//   Channel   Direction   Handshake               Contents
//   req_      in          req_tvalid/req_tready   opcode (tuser), a, b, scalar
//   rsp_      out         rsp_tvalid/rsp_tready   vector, scalar, flags
//
// One request is taken every cycle while the pipeline is not held.
// Every request passes through the 32-stage square root and the 48-stage
// divider, so results keep request order.
// Reset clears the valid bits of every stage.
// The whole pipeline holds while a result waits and rsp_tready is low.
// ----------------------------------------------------------------------------
module vector3_arithmetic_unit_top (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // ax, ay, az, bx, by, bz, scalar_in
   input  logic [223:0]             req_tdata,
   // req_type
   input  logic [v3alu_pkg::OP_W-1:0] req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // rx, ry, rz, scalar_out, is_equal, div_zero, saturated, zero fill
   output logic [135:0]             rsp_tdata
);
   import v3alu_pkg::*;

   logic adv;

   ctx_type                         s1_ctx_ff, s1_ctx_in;
   logic [2:0][DATA_W-1:0]          s1_b_ff;
   logic                            s1_vld_ff;

   ctx_type                         s2_ctx_ff, s2_ctx_in;
   logic [5:0][DATA_W-1:0]          s2_lhs_ff, s2_lhs_in, s2_rhs_ff, s2_rhs_in;
   logic                            s2_vld_ff;
   logic [2:0][DATA_W-1:0]          d_val;
   logic [2:0]                      d_ovf;

   ctx_type                         s3_ctx_ff;
   logic [5:0][PROD_W-1:0]          s3_prod_ff, s3_prod_in;
   logic                            s3_vld_ff;

   ctx_type                         s4_ctx_in;
   logic [RAD_W-1:0]                s4_rad_in;
   logic [5:0][SHPR_W-1:0]          shp;

   ctx_type                         sq_ctx_ff  [0:SQ_STAGES];
   logic [RAD_W-1:0]                sq_rad_ff  [0:SQ_STAGES];
   logic [REM_W-1:0]                sq_rem_ff  [0:SQ_STAGES];
   logic [ROOT_W-1:0]               sq_root_ff [0:SQ_STAGES];
   logic                            sq_vld_ff  [0:SQ_STAGES];

   ctx_type                         dv_ctx_ff  [0:DV_STAGES];
   logic [2:0][DIVD_W-1:0]          dv_dd_ff   [0:DV_STAGES];
   logic [2:0][DATA_W-1:0]          dv_rem_ff  [0:DV_STAGES];
   logic [2:0][DIVD_W-1:0]          dv_q_ff    [0:DV_STAGES];
   logic [DATA_W-1:0]               dv_den_ff  [0:DV_STAGES];
   logic                            dv_vld_ff  [0:DV_STAGES];

   ctx_type                         dv0_ctx_in;
   logic [DATA_W-1:0]               dv0_den_in;
   logic [2:0][DIVD_W-1:0]          dv0_dd_in;

   ctx_type                         out_ctx_ff, out_ctx_in;
   logic                            out_vld_ff;

   assign adv        = ~out_vld_ff | rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {5'b0, out_ctx_ff.st, out_ctx_ff.dz, out_ctx_ff.eq,
                        out_ctx_ff.sc, out_ctx_ff.r};

   // Stage 1: capture the request.
   always_comb begin
      s1_ctx_in    = '0;
      s1_ctx_in.op = req_tuser;
      s1_ctx_in.a  = req_tdata[95:0];
      s1_ctx_in.s  = req_tdata[223:192];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_tvalid;
      end
      if (adv) begin
         s1_ctx_ff <= s1_ctx_in;
         s1_b_ff   <= req_tdata[191:96];
      end
   end

   // Stage 2: add, subtract, negate, compare and multiplier operand selection.
   always_comb begin
      s2_ctx_in = s1_ctx_ff;
      s2_lhs_in = '0;
      s2_rhs_in = '0;
      for (int i = 0; i < 3; i++) begin
         d_val[i] = sat_val(wide32(s1_ctx_ff.a[i]) - wide32(s1_b_ff[i]));
         d_ovf[i] = sat_ovf(wide32(s1_ctx_ff.a[i]) - wide32(s1_b_ff[i]));
      end
      case (s1_ctx_ff.op)
         OP_ADD: begin
            for (int i = 0; i < 3; i++) begin
               s2_ctx_in.r[i] = sat_val(wide32(s1_ctx_ff.a[i]) + wide32(s1_b_ff[i]));
               s2_ctx_in.st   = s2_ctx_in.st |
                                sat_ovf(wide32(s1_ctx_ff.a[i]) + wide32(s1_b_ff[i]));
            end
         end
         OP_SUB: begin
            s2_ctx_in.r  = d_val;
            s2_ctx_in.st = |d_ovf;
         end
         OP_NEG: begin
            for (int i = 0; i < 3; i++) begin
               s2_ctx_in.r[i] = sat_val(-wide32(s1_ctx_ff.a[i]));
               s2_ctx_in.st   = s2_ctx_in.st | sat_ovf(-wide32(s1_ctx_ff.a[i]));
            end
         end
         OP_EQUAL: begin
            s2_ctx_in.eq = (s1_ctx_ff.a == s1_b_ff);
         end
         OP_SCALE: begin
            for (int i = 0; i < 3; i++) begin
               s2_lhs_in[i] = s1_ctx_ff.a[i];
               s2_rhs_in[i] = s1_ctx_ff.s;
            end
         end
         OP_DOT: begin
            for (int i = 0; i < 3; i++) begin
               s2_lhs_in[i] = s1_ctx_ff.a[i];
               s2_rhs_in[i] = s1_b_ff[i];
            end
         end
         OP_MAG, OP_NORM: begin
            for (int i = 0; i < 3; i++) begin
               s2_lhs_in[i] = s1_ctx_ff.a[i];
               s2_rhs_in[i] = s1_ctx_ff.a[i];
            end
         end
         OP_DIST: begin
            s2_ctx_in.st = |d_ovf;
            for (int i = 0; i < 3; i++) begin
               s2_lhs_in[i] = d_val[i];
               s2_rhs_in[i] = d_val[i];
            end
         end
         OP_CROSS: begin
            s2_lhs_in[0] = s1_ctx_ff.a[1];
            s2_rhs_in[0] = s1_b_ff[2];
            s2_lhs_in[1] = s1_ctx_ff.a[2];
            s2_rhs_in[1] = s1_b_ff[0];
            s2_lhs_in[2] = s1_ctx_ff.a[0];
            s2_rhs_in[2] = s1_b_ff[1];
            s2_lhs_in[3] = s1_ctx_ff.a[2];
            s2_rhs_in[3] = s1_b_ff[1];
            s2_lhs_in[4] = s1_ctx_ff.a[0];
            s2_rhs_in[4] = s1_b_ff[2];
            s2_lhs_in[5] = s1_ctx_ff.a[1];
            s2_rhs_in[5] = s1_b_ff[0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
      if (adv) begin
         s2_ctx_ff <= s2_ctx_in;
         s2_lhs_ff <= s2_lhs_in;
         s2_rhs_ff <= s2_rhs_in;
      end
   end

   // Stage 3: six signed multipliers.
   always_comb begin
      for (int k = 0; k < 6; k++) begin
         s3_prod_in[k] = $signed(s2_lhs_ff[k]) * $signed(s2_rhs_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s3_vld_ff <= s2_vld_ff;
      end
      if (adv) begin
         s3_ctx_ff  <= s2_ctx_ff;
         s3_prod_ff <= s3_prod_in;
      end
   end

   // Stage 4: fraction shift, sums and differences, root radicand.
   always_comb begin
      s4_ctx_in = s3_ctx_ff;
      s4_rad_in = '0;
      for (int k = 0; k < 6; k++) begin
         shp[k] = s3_prod_ff[k][PROD_W-1:FRAC_W];
      end
      case (s3_ctx_ff.op)
         OP_SCALE: begin
            for (int i = 0; i < 3; i++) begin
               s4_ctx_in.r[i] = sat_val({{2{shp[i][SHPR_W-1]}}, shp[i]});
               s4_ctx_in.st   = s4_ctx_in.st | sat_ovf({{2{shp[i][SHPR_W-1]}}, shp[i]});
            end
         end
         OP_DOT: begin
            s4_ctx_in.sc = sat_val({{2{shp[0][SHPR_W-1]}}, shp[0]} +
                                   {{2{shp[1][SHPR_W-1]}}, shp[1]} +
                                   {{2{shp[2][SHPR_W-1]}}, shp[2]});
            s4_ctx_in.st = sat_ovf({{2{shp[0][SHPR_W-1]}}, shp[0]} +
                                   {{2{shp[1][SHPR_W-1]}}, shp[1]} +
                                   {{2{shp[2][SHPR_W-1]}}, shp[2]});
         end
         OP_CROSS: begin
            for (int i = 0; i < 3; i++) begin
               s4_ctx_in.r[i] = sat_val({{2{shp[i][SHPR_W-1]}}, shp[i]} -
                                        {{2{shp[i+3][SHPR_W-1]}}, shp[i+3]});
               s4_ctx_in.st   = s4_ctx_in.st |
                                sat_ovf({{2{shp[i][SHPR_W-1]}}, shp[i]} -
                                        {{2{shp[i+3][SHPR_W-1]}}, shp[i+3]});
            end
         end
         OP_MAG, OP_DIST, OP_NORM: begin
            s4_rad_in = s3_prod_ff[0] + s3_prod_ff[1] + s3_prod_ff[2];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         sq_vld_ff[0] <= s3_vld_ff;
      end
      if (adv) begin
         sq_ctx_ff[0]  <= s4_ctx_in;
         sq_rad_ff[0]  <= s4_rad_in;
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
      end
   end

   // Square root: one root bit per stage.
   for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
      logic [REM_W+1:0]  trial;
      logic [REM_W+1:0]  part;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;

      always_comb begin
         part  = {sq_rem_ff[k], sq_rad_ff[k][RAD_W-1 -: 2]};
         trial = {2'b00, sq_root_ff[k], 2'b01};
         if (part >= trial) begin
            rem_in  = REM_W'(part - trial);
            root_in = {sq_root_ff[k][ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = part[REM_W-1:0];
            root_in = {sq_root_ff[k][ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            sq_vld_ff[k+1] <= sq_vld_ff[k];
         end
         if (adv) begin
            sq_ctx_ff[k+1]  <= sq_ctx_ff[k];
            sq_rad_ff[k+1]  <= {sq_rad_ff[k][RAD_W-3:0], 2'b00};
            sq_rem_ff[k+1]  <= rem_in;
            sq_root_ff[k+1] <= root_in;
         end
      end
   end

   // Root result and divider set-up.
   always_comb begin
      dv0_ctx_in = sq_ctx_ff[SQ_STAGES];
      dv0_den_in = '0;
      for (int i = 0; i < 3; i++) begin
         dv0_dd_in[i] = {abs32(sq_ctx_ff[SQ_STAGES].a[i]), {FRAC_W{1'b0}}};
      end
      case (sq_ctx_ff[SQ_STAGES].op)
         OP_MAG, OP_DIST: begin
            if (sq_root_ff[SQ_STAGES] > VAL_MAX) begin
               dv0_ctx_in.sc = VAL_MAX;
               dv0_ctx_in.st = 1'b1;
            end else begin
               dv0_ctx_in.sc = sq_root_ff[SQ_STAGES];
            end
         end
         OP_DIV: begin
            dv0_den_in = abs32(sq_ctx_ff[SQ_STAGES].s);
         end
         OP_NORM: begin
            dv0_den_in = sq_root_ff[SQ_STAGES];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_vld_ff[0] <= sq_vld_ff[SQ_STAGES];
      end
      if (adv) begin
         dv_ctx_ff[0] <= dv0_ctx_in;
         dv_den_ff[0] <= dv0_den_in;
         dv_dd_ff[0]  <= dv0_dd_in;
         dv_rem_ff[0] <= '0;
         dv_q_ff[0]   <= '0;
      end
   end

   // Restoring divider: one quotient bit per stage for each component.
   for (genvar j = 0; j < DV_STAGES; j++) begin : g_div
      logic [2:0][DATA_W:0]   part;
      logic [2:0][DATA_W-1:0] rem_in;
      logic [2:0][DIVD_W-1:0] q_in;
      logic [2:0][DIVD_W-1:0] dd_in;

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            part[i]  = {dv_rem_ff[j][i], dv_dd_ff[j][i][DIVD_W-1]};
            dd_in[i] = {dv_dd_ff[j][i][DIVD_W-2:0], 1'b0};
            if (part[i] >= {1'b0, dv_den_ff[j]}) begin
               rem_in[i] = DATA_W'(part[i] - {1'b0, dv_den_ff[j]});
               q_in[i]   = {dv_q_ff[j][i][DIVD_W-2:0], 1'b1};
            end else begin
               rem_in[i] = part[i][DATA_W-1:0];
               q_in[i]   = {dv_q_ff[j][i][DIVD_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[j+1] <= 1'b0;
         end else if (adv) begin
            dv_vld_ff[j+1] <= dv_vld_ff[j];
         end
         if (adv) begin
            dv_ctx_ff[j+1] <= dv_ctx_ff[j];
            dv_den_ff[j+1] <= dv_den_ff[j];
            dv_dd_ff[j+1]  <= dd_in;
            dv_rem_ff[j+1] <= rem_in;
            dv_q_ff[j+1]   <= q_in;
         end
      end
   end

   // Output stage: quotient sign, saturation and zero divisor.
   always_comb begin
      logic               neg;
      logic [DIVD_W-1:0]  q;
      out_ctx_in = dv_ctx_ff[DV_STAGES];
      neg        = 1'b0;
      q          = '0;
      if (dv_ctx_ff[DV_STAGES].op == OP_DIV || dv_ctx_ff[DV_STAGES].op == OP_NORM) begin
         if (dv_den_ff[DV_STAGES] == '0) begin
            out_ctx_in.r  = '0;
            out_ctx_in.dz = (dv_ctx_ff[DV_STAGES].op == OP_DIV);
         end else begin
            for (int i = 0; i < 3; i++) begin
               q   = dv_q_ff[DV_STAGES][i];
               neg = dv_ctx_ff[DV_STAGES].a[i][DATA_W-1] ^
                     ((dv_ctx_ff[DV_STAGES].op == OP_DIV) &
                      dv_ctx_ff[DV_STAGES].s[DATA_W-1]);
               if (neg) begin
                  if (q > DIVD_W'(VAL_MIN)) begin
                     out_ctx_in.r[i] = VAL_MIN;
                     out_ctx_in.st   = 1'b1;
                  end else begin
                     out_ctx_in.r[i] = ~q[DATA_W-1:0] + 32'd1;
                  end
               end else begin
                  if (q > DIVD_W'(VAL_MAX)) begin
                     out_ctx_in.r[i] = VAL_MAX;
                     out_ctx_in.st   = 1'b1;
                  end else begin
                     out_ctx_in.r[i] = q[DATA_W-1:0];
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= dv_vld_ff[DV_STAGES];
      end
      if (adv) begin
         out_ctx_ff <= out_ctx_in;
      end
   end

endmodule
